// File: rtl/sppl_pkg.sv
// Shared types and constants for the servo PID position loop.
// Used by sppl_ctrl, sppl_dp and servo_pid_position_loop; no dependencies.
package sppl_pkg;

	// field and internal widths
	localparam int SAMPLE_W   = 12;
	localparam int FILT_W     = 20;
	localparam int WHOLE_W    = 12;
	localparam int TARGET_W   = 9;
	localparam int GAIN_W     = 32;
	localparam int PERIOD_W   = 16;
	localparam int DUTY_W     = 16;
	localparam int ANGLE_W    = 9;
	localparam int ERR_W      = 18;
	localparam int INTEG_W    = 16;
	localparam int OPND_W     = 19;
	localparam int PROD_W     = GAIN_W + OPND_W;
	localparam int ACC_W      = PROD_W + 1;
	localparam int DRIVE_SH   = 24;
	localparam int DRIVE_W    = ACC_W - DRIVE_SH;
	localparam int QUOT_W     = 17;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TARGET = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_P = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_I = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_D = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 3'd4;

	// register reset values
	localparam logic [TARGET_W-1:0] TARGET_RST = 9'd150;
	localparam logic [GAIN_W-1:0]   GAIN_P_RST = 32'd6553600;
	localparam logic [GAIN_W-1:0]   GAIN_I_RST = 32'd3;
	localparam logic [GAIN_W-1:0]   GAIN_D_RST = 32'd524288000;
	localparam logic [PERIOD_W-1:0] PERIOD_RST = 16'd1199;

	// filter weights (out of 256)
	localparam int EMA_NEW = 26;
	localparam int EMA_OLD = 230;

	// error scaling: 76800/4095 = 18 + 3090/4095
	localparam int DIV_K    = 4095;
	localparam int FRAC_MUL = 3090;
	localparam int INT_MUL  = 18;
	localparam int ANGLE_MUL = 600;

	localparam int INTEGRAL_LIMIT = 25600;
	localparam int DEADBAND       = 384;

	// multiplier operand select
	localparam logic [1:0] MUL_P = 2'd0;
	localparam logic [1:0] MUL_I = 2'd1;
	localparam logic [1:0] MUL_D = 2'd2;

	typedef struct packed {
		logic [TARGET_W-1:0] target;
		logic [GAIN_W-1:0]   gain_p;
		logic [GAIN_W-1:0]   gain_i;
		logic [GAIN_W-1:0]   gain_d;
		logic [PERIOD_W-1:0] period;
	} cfg_t;

	typedef struct packed {
		logic       ld_sample;
		logic       filt_en;
		logic       div_en;
		logic       err_en;
		logic       int_en;
		logic       pid_clr;
		logic       mul_en;
		logic [1:0] mul_sel;
		logic       acc_ld;
		logic       acc_add;
		logic       out_ld;
	} cmd_t;

	typedef struct packed {
		logic dead;
		logic out_busy;
	} stat_t;

endpackage

// File: rtl/servo_pid_position_loop.sv
// Top level of the servo PID position loop: configuration registers, sequencer
// and datapath. Depends on sppl_pkg, sppl_ctrl, sppl_dp.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+-----------
//  cfg     | cfg_valid/cfg_ready, cfg_index, cfg_data  | in
//  in      | in_valid/in_ready, adc_sample             | in
//  out     | out_valid/out_ready, forward_duty,        | out
//          | backward_duty, in_deadband, angle_deg     |
//
// Each sample is stepped by the sequencer through filter, divide, error,
// integral, then three passes through the shared 32x19 multiplier and an
// accumulate; inside the deadband the multiplier passes and accumulate are skipped.
// A new sample is taken in the cycle after the result is loaded, while that
// result still waits in the output register; the final step stalls while the
// output register holds an untaken result.
// Reset clears the filter, integral, previous error and loads register defaults.
module servo_pid_position_loop (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [sppl_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [sppl_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [sppl_pkg::SAMPLE_W-1:0]     adc_sample,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [sppl_pkg::DUTY_W-1:0]       forward_duty,
	output logic [sppl_pkg::DUTY_W-1:0]       backward_duty,
	output logic                              in_deadband,
	output logic [sppl_pkg::ANGLE_W-1:0]      angle_deg
);
	import sppl_pkg::*;

	cfg_t  cfg_q;
	cmd_t  cmd;
	stat_t stat;

	assign cfg_ready = 1'b1;

	// configuration registers; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target <= TARGET_RST;
			cfg_q.gain_p <= GAIN_P_RST;
			cfg_q.gain_i <= GAIN_I_RST;
			cfg_q.gain_d <= GAIN_D_RST;
			cfg_q.period <= PERIOD_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_TARGET: cfg_q.target <= cfg_data[TARGET_W-1:0];
				REG_GAIN_P: cfg_q.gain_p <= cfg_data;
				REG_GAIN_I: cfg_q.gain_i <= cfg_data;
				REG_GAIN_D: cfg_q.gain_d <= cfg_data;
				REG_PERIOD: cfg_q.period <= cfg_data[PERIOD_W-1:0];
				default: begin
				end
			endcase
		end
	end

	sppl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	sppl_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.cfg           (cfg_q),
		.adc_sample    (adc_sample),
		.out_ready     (out_ready),
		.out_valid     (out_valid),
		.forward_duty  (forward_duty),
		.backward_duty (backward_duty),
		.in_deadband   (in_deadband),
		.angle_deg     (angle_deg),
		.stat          (stat)
	);

endmodule

// File: rtl/sppl_ctrl.sv
// Sequencer for the servo PID position loop: steps one sample through the datapath.
// Depends on sppl_pkg.
module sppl_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic            out_ready,
	input  sppl_pkg::stat_t stat,
	output sppl_pkg::cmd_t  cmd
);
	import sppl_pkg::*;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_FILT = 4'd1;
	localparam logic [3:0] S_DIV  = 4'd2;
	localparam logic [3:0] S_ERR  = 4'd3;
	localparam logic [3:0] S_INT  = 4'd4;
	localparam logic [3:0] S_MI   = 4'd5;
	localparam logic [3:0] S_MD   = 4'd6;
	localparam logic [3:0] S_ACC  = 4'd7;
	localparam logic [3:0] S_OUT  = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_nxt;

	assign in_ready = (state_q == S_IDLE);

	// next state and datapath commands
	always_comb begin
		state_nxt = state_q;
		cmd = '0;
		cmd.mul_sel = MUL_P;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.ld_sample = 1'b1;
					state_nxt = S_FILT;
				end
			end
			S_FILT: begin
				cmd.filt_en = 1'b1;
				state_nxt = S_DIV;
			end
			S_DIV: begin
				cmd.div_en = 1'b1;
				state_nxt = S_ERR;
			end
			S_ERR: begin
				cmd.err_en = 1'b1;
				state_nxt = S_INT;
			end
			S_INT: begin
				if (stat.dead) begin
					cmd.pid_clr = 1'b1;
					state_nxt = S_OUT;
				end else begin
					cmd.int_en = 1'b1;
					cmd.mul_en = 1'b1;
					cmd.mul_sel = MUL_P;
					state_nxt = S_MI;
				end
			end
			S_MI: begin
				cmd.mul_en = 1'b1;
				cmd.mul_sel = MUL_I;
				cmd.acc_ld = 1'b1;
				state_nxt = S_MD;
			end
			S_MD: begin
				cmd.mul_en = 1'b1;
				cmd.mul_sel = MUL_D;
				cmd.acc_add = 1'b1;
				state_nxt = S_ACC;
			end
			S_ACC: begin
				cmd.acc_add = 1'b1;
				state_nxt = S_OUT;
			end
			S_OUT: begin
				// hold until the previous result has been taken
				if (!stat.out_busy || out_ready) begin
					cmd.out_ld = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// an accepted sample always enters the filter step next
	a_accept_filt: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> cmd.filt_en)
		else $error("filter step missing after transfer");

endmodule

// File: rtl/sppl_dp.sv
// Datapath for the servo PID position loop: filter, error, PID with a shared
// multiplier, output register. Depends on sppl_pkg.
module sppl_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  sppl_pkg::cmd_t                    cmd,
	input  sppl_pkg::cfg_t                    cfg,
	input  logic [sppl_pkg::SAMPLE_W-1:0]     adc_sample,
	input  logic                              out_ready,
	output logic                              out_valid,
	output logic [sppl_pkg::DUTY_W-1:0]       forward_duty,
	output logic [sppl_pkg::DUTY_W-1:0]       backward_duty,
	output logic                              in_deadband,
	output logic [sppl_pkg::ANGLE_W-1:0]      angle_deg,
	output sppl_pkg::stat_t                   stat
);
	import sppl_pkg::*;

	// state and working registers
	logic [SAMPLE_W-1:0]      sample_q;
	logic [FILT_W-1:0]        filt_q;
	logic                     seeded_q;
	logic [QUOT_W-1:0]        quot_q;
	logic                     rnz_q;
	logic [ANGLE_W-1:0]       angle_q;
	logic signed [ERR_W-1:0]  err_q;
	logic                     dead_q;
	logic signed [INTEG_W-1:0] integ_q;
	logic signed [ERR_W-1:0]  last_q;
	logic signed [OPND_W-1:0] diff_q;
	logic signed [PROD_W-1:0] prod_s1;
	logic signed [ACC_W-1:0]  acc_q;
	logic                     out_valid_q;
	logic [DUTY_W-1:0]        fwd_q;
	logic [DUTY_W-1:0]        bwd_q;
	logic                     held_q;
	logic [ANGLE_W-1:0]       angle_out_q;

	// combinational values
	logic [27:0]               ema_sum;
	logic [FILT_W-1:0]         filt_nxt;
	logic [WHOLE_W-1:0]        whole;
	logic [23:0]               frac_y;
	logic [12:0]               frac_s;
	logic                      frac_ge;
	logic [QUOT_W-1:0]         quot_nxt;
	logic                      rnz_nxt;
	logic [21:0]               ang_z;
	logic [20:0]               ang_z2;
	logic [12:0]               ang_s;
	logic [ANGLE_W-1:0]        angle_nxt;
	logic [QUOT_W-1:0]         tgt_q8;
	logic [QUOT_W-1:0]         quot_ceil;
	logic signed [ERR_W-1:0]   err_nxt;
	logic [ERR_W-1:0]          err_mag;
	logic signed [OPND_W-1:0]  isum;
	logic signed [INTEG_W-1:0] integ_nxt;
	logic signed [OPND_W-1:0]  diff_nxt;
	logic signed [GAIN_W-1:0]  mul_a;
	logic signed [OPND_W-1:0]  mul_b;
	logic signed [DRIVE_W-1:0] drive;
	logic                      drv_pos;
	logic [DRIVE_W-1:0]        drv_mag;
	logic [DUTY_W-1:0]         duty;

	// moving average, seeded by the first sample
	always_comb begin
		ema_sum = 28'({sample_q, 8'h00}) * 28'(EMA_NEW) + 28'(filt_q) * 28'(EMA_OLD);
		filt_nxt = seeded_q ? ema_sum[27:8] : {sample_q, 8'h00};
	end

	// floor and remainder flag of whole*76800/4095, plus rounded angle;
	// 2^12 = 4095 + 1, so a split at bit 12 needs one correction
	always_comb begin
		whole = filt_q[FILT_W-1:8];
		frac_y = 24'(whole) * 24'(FRAC_MUL);
		frac_s = 13'(frac_y[23:12]) + 13'(frac_y[11:0]);
		frac_ge = (frac_s >= 13'(DIV_K));
		quot_nxt = QUOT_W'(whole) * QUOT_W'(INT_MUL) + QUOT_W'(frac_y[23:12])
			+ QUOT_W'(frac_ge);
		rnz_nxt = frac_ge ? (frac_s != 13'(DIV_K)) : (frac_s != 13'd0);
		ang_z = 22'(whole) * 22'(ANGLE_MUL) + 22'(DIV_K);
		ang_z2 = ang_z[21:1];
		ang_s = 13'(ang_z2[20:12]) + 13'(ang_z2[11:0]);
		angle_nxt = ang_z2[20:12] + ANGLE_W'(ang_s >= 13'(DIV_K));
	end

	// error truncated toward zero: ceil when positive, floor when negative
	always_comb begin
		tgt_q8 = {cfg.target, 8'h00};
		quot_ceil = quot_q + QUOT_W'(rnz_q);
		if (tgt_q8 >= quot_ceil) begin
			err_nxt = ERR_W'(tgt_q8) - ERR_W'(quot_ceil);
		end else begin
			err_nxt = ERR_W'(tgt_q8) - ERR_W'(quot_q);
		end
		err_mag = err_nxt[ERR_W-1] ? ERR_W'(-err_nxt) : ERR_W'(err_nxt);
	end

	// integral with clamp, derivative difference
	always_comb begin
		isum = {{(OPND_W-INTEG_W){integ_q[INTEG_W-1]}}, integ_q}
			+ {{(OPND_W-ERR_W){err_q[ERR_W-1]}}, err_q};
		if (isum > OPND_W'(INTEGRAL_LIMIT)) begin
			integ_nxt = INTEG_W'(INTEGRAL_LIMIT);
		end else if (isum < -OPND_W'(INTEGRAL_LIMIT)) begin
			integ_nxt = -INTEG_W'(INTEGRAL_LIMIT);
		end else begin
			integ_nxt = isum[INTEG_W-1:0];
		end
		diff_nxt = {err_q[ERR_W-1], err_q} - {last_q[ERR_W-1], last_q};
	end

	// shared multiplier operands
	always_comb begin
		case (cmd.mul_sel)
			MUL_P: begin
				mul_a = cfg.gain_p;
				mul_b = {err_q[ERR_W-1], err_q};
			end
			MUL_I: begin
				mul_a = cfg.gain_i;
				mul_b = {{(OPND_W-INTEG_W){integ_q[INTEG_W-1]}}, integ_q};
			end
			default: begin
				mul_a = cfg.gain_d;
				mul_b = diff_q;
			end
		endcase
	end

	// floor shift, magnitude clamp, steering
	always_comb begin
		drive = acc_q[ACC_W-1:DRIVE_SH];
		drv_pos = !drive[DRIVE_W-1] && (drive != '0);
		drv_mag = drive[DRIVE_W-1] ? DRIVE_W'(-drive) : DRIVE_W'(drive);
		duty = (drv_mag > DRIVE_W'(cfg.period)) ? cfg.period : drv_mag[DUTY_W-1:0];
	end

	// loop state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filt_q <= '0;
			seeded_q <= 1'b0;
			integ_q <= '0;
			last_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.filt_en) begin
				filt_q <= filt_nxt;
				seeded_q <= 1'b1;
			end
			if (cmd.pid_clr) begin
				integ_q <= '0;
				last_q <= '0;
			end else if (cmd.int_en) begin
				integ_q <= integ_nxt;
				last_q <= err_q;
			end
			if (cmd.out_ld) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// working and payload registers
	always_ff @(posedge clk) begin
		if (cmd.ld_sample) begin
			sample_q <= adc_sample;
		end
		if (cmd.div_en) begin
			quot_q <= quot_nxt;
			rnz_q <= rnz_nxt;
			angle_q <= angle_nxt;
		end
		if (cmd.err_en) begin
			err_q <= err_nxt;
			dead_q <= (err_mag < ERR_W'(DEADBAND));
		end
		if (cmd.int_en) begin
			diff_q <= diff_nxt;
		end
		if (cmd.mul_en) begin
			prod_s1 <= mul_a * mul_b;
		end
		if (cmd.acc_ld) begin
			acc_q <= {prod_s1[PROD_W-1], prod_s1};
		end else if (cmd.acc_add) begin
			acc_q <= acc_q + {prod_s1[PROD_W-1], prod_s1};
		end
		if (cmd.out_ld) begin
			held_q <= dead_q;
			angle_out_q <= angle_q;
			fwd_q <= (!dead_q && drv_pos) ? duty : '0;
			bwd_q <= (!dead_q && !drv_pos) ? duty : '0;
		end
	end

	assign stat.dead = dead_q;
	assign stat.out_busy = out_valid_q;
	assign out_valid = out_valid_q;
	assign forward_duty = fwd_q;
	assign backward_duty = bwd_q;
	assign in_deadband = held_q;
	assign angle_deg = angle_out_q;

	a_integ_range: assert property (@(posedge clk) disable iff (!arst_n)
		(integ_q <= INTEG_W'(INTEGRAL_LIMIT)) && (integ_q >= -INTEG_W'(INTEGRAL_LIMIT)))
		else $error("integral outside clamp");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_ld |-> (!out_valid_q || out_ready))
		else $error("result overwritten before transfer");

	a_one_channel: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ((fwd_q == '0) || (bwd_q == '0))
			&& (!held_q || ((fwd_q == '0) && (bwd_q == '0))))
		else $error("both channels driven or held with drive");

endmodule

// File: sim/servo_pid_position_loop_chk.sv
`timescale 1ns / 100ps
// Checker for the servo PID position loop: follows config, sample and result
// transfers, predicts every result and compares it field by field.
// Depends on sppl_pkg for widths, register indexes and reset values.
module servo_pid_position_loop_chk (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic [sppl_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sppl_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	input  logic                            in_ready,
	input  logic [sppl_pkg::SAMPLE_W-1:0]   adc_sample,
	input  logic                            out_valid,
	input  logic                            out_ready,
	input  logic [sppl_pkg::DUTY_W-1:0]     forward_duty,
	input  logic [sppl_pkg::DUTY_W-1:0]     backward_duty,
	input  logic                            in_deadband,
	input  logic [sppl_pkg::ANGLE_W-1:0]    angle_deg,
	output int                              fail_count,
	output int                              pending
);
	import sppl_pkg::*;

	// error scaling: target degrees and whole ADC counts into Q8 degrees
	localparam longint TGT_SCALE = 1048320;
	localparam longint POS_SCALE = 76800;

	typedef struct packed {
		logic [DUTY_W-1:0]  fwd;
		logic [DUTY_W-1:0]  bwd;
		logic               held;
		logic [ANGLE_W-1:0] angle;
	} tick_result_t;

	tick_result_t awaited_q[$];
	int errs = 0;
	int queued = 0;

	// predicted loop state
	logic [FILT_W-1:0]          filt_q8;
	logic                       seeded;
	longint                     integ_sum;
	longint                     prev_err;

	// shadow of the config registers
	logic [TARGET_W-1:0]        k_target;
	logic signed [GAIN_W-1:0]   k_p;
	logic signed [GAIN_W-1:0]   k_i;
	logic signed [GAIN_W-1:0]   k_d;
	logic [PERIOD_W-1:0]        k_period;

	assign fail_count = errs;
	assign pending    = queued;

	task automatic log_mismatch(input string msg);
		$display("[%0t] servo loop mismatch: %s", $time, msg);
		errs++;
	endtask

	// Advance the filter and the PID by one tick and return the expected result
	function automatic tick_result_t predict_tick(input logic [SAMPLE_W-1:0] sample);
		tick_result_t r;
		longint whole, err, acc, sum, drive, mag;
		if (!seeded) begin
			filt_q8 = {sample, 8'd0};
			seeded  = 1'b1;
		end else begin
			acc = (longint'(EMA_NEW) * (longint'(sample) << 8) +
				longint'(EMA_OLD) * longint'(filt_q8)) >> 8;
			filt_q8 = acc[FILT_W-1:0];
		end
		whole = longint'(filt_q8 >> 8);
		// signed division truncates toward zero
		err = (longint'(k_target) * TGT_SCALE - whole * POS_SCALE) / DIV_K;
		acc = (whole * ANGLE_MUL + DIV_K) / (2 * DIV_K);
		r.angle = acc[ANGLE_W-1:0];
		r.fwd   = '0;
		r.bwd   = '0;
		r.held  = 1'b0;
		if ((err < 0 ? -err : err) < DEADBAND) begin
			// hold the motor and clear the PID history
			r.held    = 1'b1;
			integ_sum = 0;
			prev_err  = 0;
		end else begin
			acc = integ_sum + err;
			if (acc > INTEGRAL_LIMIT)
				acc = INTEGRAL_LIMIT;
			else if (acc < -INTEGRAL_LIMIT)
				acc = -INTEGRAL_LIMIT;
			integ_sum = acc;
			sum = longint'(k_p) * err + longint'(k_i) * acc + longint'(k_d) * (err - prev_err);
			prev_err = err;
			// floor to whole counts, clamp the magnitude, steer by sign
			drive = sum >>> DRIVE_SH;
			mag = (drive < 0) ? -drive : drive;
			if (mag > longint'(k_period))
				mag = longint'(k_period);
			if (drive > 0)
				r.fwd = mag[DUTY_W-1:0];
			else
				r.bwd = mag[DUTY_W-1:0];
		end
		return r;
	endfunction

	// Watch all three channels on every edge
	always @(posedge clk or negedge arst_n) begin
		tick_result_t want;
		if (!arst_n) begin
			filt_q8   = '0;
			seeded    = 1'b0;
			integ_sum = 0;
			prev_err  = 0;
			k_target  = TARGET_RST;
			k_p       = GAIN_P_RST;
			k_i       = GAIN_I_RST;
			k_d       = GAIN_D_RST;
			k_period  = PERIOD_RST;
			awaited_q.delete();
			queued <= 0;
		end else begin
			// compare a result transfer against the oldest prediction
			if (out_valid && out_ready) begin
				if (awaited_q.size() == 0) begin
					log_mismatch("result transfer with no prediction waiting");
				end else begin
					want = awaited_q.pop_front();
					if (forward_duty !== want.fwd)
						log_mismatch($sformatf("forward_duty got %0d want %0d",
							forward_duty, want.fwd));
					if (backward_duty !== want.bwd)
						log_mismatch($sformatf("backward_duty got %0d want %0d",
							backward_duty, want.bwd));
					if (in_deadband !== want.held)
						log_mismatch($sformatf("in_deadband got %0b want %0b",
							in_deadband, want.held));
					if (angle_deg !== want.angle)
						log_mismatch($sformatf("angle_deg got %0d want %0d",
							angle_deg, want.angle));
				end
			end
			// track register writes; unknown indexes are dropped
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
				REG_TARGET: k_target = cfg_data[TARGET_W-1:0];
				REG_GAIN_P: k_p      = cfg_data;
				REG_GAIN_I: k_i      = cfg_data;
				REG_GAIN_D: k_d      = cfg_data;
				REG_PERIOD: k_period = cfg_data[PERIOD_W-1:0];
				default: ;
				endcase
			end
			// predict a sample transfer
			if (in_valid && in_ready)
				awaited_q.push_back(predict_tick(adc_sample));
			queued <= awaited_q.size();
		end
	end

endmodule

// File: sim/servo_pid_position_loop_tb.sv
`timescale 1ns / 100ps
// Testbench top for the servo PID position loop: clock, reset, sample and
// config stimulus, output back-pressure and the verdict.
// Depends on sppl_pkg, servo_pid_position_loop and servo_pid_position_loop_chk.
module servo_pid_position_loop_tb;
	import sppl_pkg::*;

	localparam int HOLD_CYCLES = 300;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [SAMPLE_W-1:0]   adc_sample = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [DUTY_W-1:0]     forward_duty;
	logic [DUTY_W-1:0]     backward_duty;
	logic                  in_deadband;
	logic [ANGLE_W-1:0]    angle_deg;

	int                    fail_count;
	int                    pending;
	int                    send_idle = 0;
	int                    stall_pct = 0;
	logic                  hold_phase = 1'b0;
	int                    hold_cnt = 0;
	logic [TARGET_W-1:0]   aim_target = TARGET_RST;

	servo_pid_position_loop DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.adc_sample    (adc_sample),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.forward_duty  (forward_duty),
		.backward_duty (backward_duty),
		.in_deadband   (in_deadband),
		.angle_deg     (angle_deg)
	);

	servo_pid_position_loop_chk loop_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.adc_sample    (adc_sample),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.forward_duty  (forward_duty),
		.backward_duty (backward_duty),
		.in_deadband   (in_deadband),
		.angle_deg     (angle_deg),
		.fail_count    (fail_count),
		.pending       (pending)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Drive out_ready: one long hold per pressure phase, random stalls otherwise
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_cnt  <= 0;
		end else if (hold_phase && hold_cnt < HOLD_CYCLES) begin
			out_ready <= 1'b0;
			hold_cnt  <= hold_cnt + 1;
		end else begin
			if (!hold_phase)
				hold_cnt <= 0;
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Offer one sample, idling first at the current rate, and wait for its transfer
	task automatic send_sample(input logic [SAMPLE_W-1:0] value);
		while (send_idle != 0 && $urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		adc_sample <= value;
		do @(posedge clk); while (!in_ready);
	endtask

	// Drop valid and wait until every predicted result has been taken
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	// Offer one register write; the caller drops cfg_valid after the batch
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic program_loop(input logic [TARGET_W-1:0] tgt, input logic [GAIN_W-1:0] gp,
		input logic [GAIN_W-1:0] gi, input logic [GAIN_W-1:0] gd,
		input logic [PERIOD_W-1:0] per);
		settle();
		write_reg(REG_TARGET, CFG_DATA_W'(tgt));
		write_reg(REG_GAIN_P, gp);
		write_reg(REG_GAIN_I, gi);
		write_reg(REG_GAIN_D, gd);
		write_reg(REG_PERIOD, CFG_DATA_W'(per));
		cfg_valid  <= 1'b0;
		aim_target = tgt;
	endtask

	// Gain near working scale, fully random, or an extreme
	function automatic logic [GAIN_W-1:0] pick_gain(input int mag_bits);
		int unsigned sel;
		logic [GAIN_W-1:0] g;
		sel = $urandom_range(99);
		if (sel < 50) begin
			g = $urandom_range((1 << mag_bits) - 1);
			if ($urandom_range(9) < 3)
				g = -g;
		end else if (sel < 80) begin
			g = $urandom;
		end else begin
			case ($urandom_range(4))
			0: g = '0;
			1: g = 32'h8000_0000;
			2: g = 32'h7FFF_FFFF;
			3: g = 32'd1;
			default: g = '1;
			endcase
		end
		return g;
	endfunction

	task automatic program_random();
		logic [TARGET_W-1:0] tgt;
		logic [PERIOD_W-1:0] per;
		int unsigned sel;
		if ($urandom_range(99) < 85)
			tgt = TARGET_W'($urandom_range(280, 45));
		else
			tgt = TARGET_W'($urandom);
		sel = $urandom_range(99);
		if (sel < 20)
			per = ($urandom_range(1) != 0) ? '1 : '0;
		else if (sel < 60)
			per = PERIOD_W'($urandom_range(2000, 1));
		else
			per = PERIOD_W'($urandom);
		program_loop(tgt, pick_gain(24), pick_gain(10), pick_gain(30), per);
	endtask

	// Mostly steady runs around a set point so the filter settles, plus noise and rails
	task automatic run_mix(input int count);
		int left, level, run_len, v;
		int unsigned sel;
		left = count;
		while (left > 0) begin
			sel = $urandom_range(99);
			if (sel < 60) begin
				if ($urandom_range(1) != 0)
					level = int'(aim_target) * 4095 / 300 + int'($urandom_range(60)) - 30;
				else
					level = int'($urandom_range(4095));
				run_len = $urandom_range(40, 8);
				if (run_len > left)
					run_len = left;
				repeat (run_len) begin
					v = level + int'($urandom_range(8)) - 4;
					if (v < 0)
						v = 0;
					else if (v > 4095)
						v = 4095;
					send_sample(SAMPLE_W'(v));
				end
				left -= run_len;
			end else if (sel < 85) begin
				send_sample(SAMPLE_W'($urandom_range(4095)));
				left--;
			end else begin
				send_sample(($urandom_range(1) != 0) ? 12'hFFF : 12'h000);
				left--;
			end
		end
	endtask

	task automatic run_phase(input int send_pct, input int recv_pct);
		repeat (2) begin
			program_random();
			send_idle = send_pct;
			stall_pct <= recv_pct;
			run_mix(140);
		end
	endtask

	// Main stimulus and verdict
	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset config: seed at the target, then rails and a step away
		send_sample(12'd2048);
		send_sample(12'd2048);
		send_sample(12'd2040);
		send_sample(12'd0);
		send_sample(12'd0);
		repeat (4) send_sample(12'd4095);
		send_sample(12'd1);
		send_sample(12'd4094);

		// zero gains give zero drive on the backward channel
		program_loop(9'd280, '0, '0, '0, PERIOD_RST);
		send_sample(12'd0);
		send_sample(12'd4095);

		// zero period forces both duties to zero
		program_loop(TARGET_RST, GAIN_P_RST, GAIN_I_RST, GAIN_D_RST, '0);
		send_sample(12'd0);
		send_sample(12'd4095);

		// target and gain extremes with the widest period
		program_loop('1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, '1);
		send_sample(12'd0);
		send_sample(12'd0);
		send_sample(12'd4095);
		program_loop('0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, '1);
		send_sample(12'd4095);
		send_sample(12'd0);
		send_sample(12'd2730);

		// writes to unused indexes must leave the loop untouched
		settle();
		for (int k = 1; k <= 3; k++)
			write_reg(REG_PERIOD + 3'(k), $urandom);
		cfg_valid <= 1'b0;
		send_sample(12'd0);
		send_sample(12'd4095);

		// random phases across idle and stall rates
		run_phase(0, 0);
		run_phase(82, 0);
		run_phase(0, 82);
		run_phase(20, 20);

		// back-pressure: receiver holds off while samples keep coming
		settle();
		send_idle = 0;
		stall_pct <= 0;
		hold_phase <= 1'b1;
		run_mix(40);
		settle();
		hold_phase <= 1'b0;
		repeat (20) @(posedge clk);

		if (fail_count == 0)
			$display("servo_pid_position_loop_tb: clean");
		else
			$display("servo_pid_position_loop_tb: errors");
		$finish;
	end

	// Stop a hung run
	initial begin
		#4_000_000;
		$display("servo_pid_position_loop_tb: errors");
		$finish;
	end

endmodule

// File: servo_pid_position_loop.f
rtl/sppl_pkg.sv
rtl/sppl_ctrl.sv
rtl/sppl_dp.sv
rtl/servo_pid_position_loop.sv
sim/servo_pid_position_loop_chk.sv
sim/servo_pid_position_loop_tb.sv
